/* rtl/assert_macros.svh */
// Assertion helpers for the checker in csa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/csa_pkg.sv */
package csa_pkg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef enum logic {
        OP_SAVE = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_GARBAGE_THRESHOLD = 3'd0;
    localparam logic [31:0] GARBAGE_THRESHOLD_RESET = 32'd1048576;

    localparam int unsigned IDX_W = 12;
    localparam int unsigned REQ_W = 17;

endpackage

/* rtl/chunk_slot_space_allocator.sv */
// Chunk slot space allocator. Keeps one slot entry (byte position, byte size)
// per chunk index in a single-port-write, registered-read table RAM, plus a
// 32-bit end pointer and a 32-bit garbage count. A save of a size that fits
// the slot's stored size stays in place and the difference goes to garbage;
// a larger size is placed at the end pointer, which advances, and the whole
// old size goes to garbage. A load returns existence, position and size.
// Every result carries the slot's header entry address (8 + 8*index) and a
// compaction request flag (garbage >= garbage_threshold, APB register 0).
// Indexes at or above SLOTS change nothing and report an empty slot.
// Flow: an item is read from the table as it is accepted, then modified and
// written back in the lookup state; no new item is accepted before that
// write-back, but the next one is taken while the previous result still sits
// in the output register. The result register stalls the write-back only
// while it is still full. After reset the table is cleared by a pass over
// min(SLOTS,4096) entries, one entry per cycle, during which no beat is
// accepted; APB writes work throughout. Record sizes above MAX_RECORD_BYTES are clamped.
module chunk_slot_space_allocator #(
    parameter int SLOTS            = 4096,
    parameter int MAX_RECORD_BYTES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [csa_pkg::IDX_W-1:0]     i_slot_index,
    input  logic [csa_pkg::REQ_W-1:0]     i_record_size,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_exists,
    output logic [31:0]                   o_record_position,
    output logic [31:0]                   o_stored_size,
    output logic                          o_appended,
    output logic [31:0]                   o_header_address,
    output logic                          o_compact_needed,
    // APB config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import csa_pkg::*;

    // Table depth: the index field is 12 bits, so never more than 4096 rows.
    localparam int DEPTH = (SLOTS < 4096) ? SLOTS : 4096;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_RECORD_BYTES + 1);
    localparam int EW    = 32 + SW;
    localparam logic [31:0] END_RESET  = 32'((2 * SLOTS + 2) * 4);
    localparam logic [31:0] MAX_BYTES  = 32'(MAX_RECORD_BYTES);
    localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr;
    logic [31:0]   r_end, n_end;
    logic [31:0]   r_garb, n_garb;
    logic [31:0]   r_thresh;

    // captured request
    logic             r_op;
    logic [IDX_W-1:0] r_idx;
    logic             r_inr;
    logic [SW-1:0]    r_new;

    // result register
    logic          r_out_valid;
    logic          r_exists, n_exists;
    logic [31:0]   r_pos, n_pos;
    logic [SW-1:0] r_size, n_size;
    logic          r_app, n_app;
    logic [31:0]   r_hdr;
    logic          r_cmp;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic          in_acc;
    logic          step;
    logic          in_range;
    logic [31:0]   req_ext;
    logic [31:0]   req_sat;
    logic [31:0]   old_pos;
    logic [SW-1:0] old_size;
    logic          grow;
    logic [31:0]   save_pos;
    logic          cfg_we;

    csa_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (i_slot_index[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = 32'(i_slot_index) < 32'(SLOTS);

    // clamp oversized records
    assign req_ext = 32'(i_record_size);
    assign req_sat = (req_ext > MAX_BYTES) ? MAX_BYTES : req_ext;

    // slot entry as read: {position, size}
    assign old_pos  = ram_rdata[EW-1:SW];
    assign old_size = ram_rdata[SW-1:0];
    assign grow     = old_size < r_new;
    assign save_pos = grow ? r_end : old_pos;

    // FSM: clear pass, wait for a request, then read-modify-write
    always_comb begin
        n_state   = r_state;
        step      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = {save_pos, r_new};
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // wait only while the previous result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    step    = 1'b1;
                    ram_we  = r_inr && (r_op == OP_SAVE);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // result and counter update
    always_comb begin
        n_end    = r_end;
        n_garb   = r_garb;
        n_exists = 1'b0;
        n_pos    = '0;
        n_size   = '0;
        n_app    = 1'b0;
        if (r_inr) begin
            if (r_op == OP_SAVE) begin
                if (grow) begin
                    n_end  = r_end + 32'(r_new);
                    n_garb = r_garb + 32'(old_size);
                end else begin
                    n_garb = r_garb + 32'(old_size - r_new);
                end
                n_exists = (save_pos != '0);
                n_pos    = save_pos;
                n_size   = r_new;
                n_app    = grow;
            end else begin
                n_exists = (old_pos != '0);
                n_pos    = old_pos;
                n_size   = old_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_end       <= END_RESET;
            r_garb      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (step) begin
                r_end       <= n_end;
                r_garb      <= n_garb;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_op;
            r_idx <= i_slot_index;
            r_inr <= in_range;
            r_new <= req_sat[SW-1:0];
        end
        if (step) begin
            r_exists <= n_exists;
            r_pos    <= n_pos;
            r_size   <= n_size;
            r_app    <= n_app;
            // 8 + 8*index, never wraps for a 12-bit index
            r_hdr    <= {17'd0, r_idx, 3'd0} + 32'd8;
            r_cmp    <= (n_garb >= r_thresh);
        end
    end

    // APB register
    assign cfg_we = psel && penable && pwrite && (paddr == REG_GARBAGE_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= GARBAGE_THRESHOLD_RESET;
        end else if (cfg_we) begin
            r_thresh <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_GARBAGE_THRESHOLD) ? r_thresh : 32'd0;

    assign o_out_valid       = r_out_valid;
    assign o_exists          = r_exists;
    assign o_record_position = r_pos;
    assign o_stored_size     = 32'(r_size);
    assign o_appended        = r_app;
    assign o_header_address  = r_hdr;
    assign o_compact_needed  = r_cmp;

endmodule

/* rtl/csa_ram.sv */
module csa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/csa_checker.sv */
`include "assert_macros.svh"

module csa_checker #(
    parameter int MAX_RECORD_BYTES = 65536
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_appended,
    input logic [31:0] o_record_position,
    input logic [31:0] o_stored_size,
    input logic [31:0] o_header_address
);

    logic out_stall;
    logic hdr_ok;
    logic size_ok;

    assign out_stall = o_out_valid && !i_out_ready;
    // header entries are 8-byte aligned and start after the 8-byte file header
    assign hdr_ok    = (o_header_address[2:0] == 3'd0) && (o_header_address != 32'd0);
    // an appended record always grew, so it is nonzero and within the clamp
    assign size_ok   = (o_stored_size != 32'd0) && (o_stored_size <= 32'(MAX_RECORD_BYTES));

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_record_position))
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMP(a_hdr_aligned, i_clk, i_rst_n, o_out_valid, hdr_ok)
    `ASSERT_IMP(a_append_size, i_clk, i_rst_n, o_out_valid && o_appended, size_ok)

endmodule

bind chunk_slot_space_allocator csa_checker #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
) u_csa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_appended        (o_appended),
    .o_record_position (o_record_position),
    .o_stored_size     (o_stored_size),
    .o_header_address  (o_header_address)
);

/* dv/tb_chunk_slot_space_allocator.sv */
`timescale 1ns / 1ps

module tb_chunk_slot_space_allocator;
    import csa_pkg::*;

    localparam int SLOTS            = 4096;
    localparam int MAX_RECORD_BYTES = 65536;
    localparam int HOT_SLOTS        = 32;

    // ------------------------------------------------------------------
    // Clock, reset and every block input start at a known value.
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_op          = 1'b0;
    logic [IDX_W-1:0]     i_slot_index  = '0;
    logic [REQ_W-1:0]     i_record_size = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [31:0]          pwdata        = '0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_exists;
    logic [31:0]          o_record_position;
    logic [31:0]          o_stored_size;
    logic                 o_appended;
    logic [31:0]          o_header_address;
    logic                 o_compact_needed;
    logic [31:0]          prdata;
    logic                 pready;

    // one result beat, field for field
    typedef struct packed {
        logic        exists;
        logic [31:0] position;
        logic [31:0] size;
        logic        appended;
        logic [31:0] header;
        logic        compact;
    } t_slot_result;

    // ------------------------------------------------------------------
    // Scoreboard: shadow copy of the slot table, end pointer and garbage
    // count. Every accepted request is placed here in order and the
    // predicted result waits in placements_due until the block reports it.
    // ------------------------------------------------------------------
    class slot_space_scoreboard;
        bit [31:0]    slot_pos  [SLOTS];
        bit [31:0]    slot_len  [SLOTS];
        bit [31:0]    end_ptr;
        bit [31:0]    garbage;
        bit [31:0]    threshold;
        t_slot_result placements_due[$];
        int           errors;
        int           n_saves;
        int           n_appends;
        int           n_loads;
        int           n_compact;
        int           n_thresholds;

        function new();
            foreach (slot_pos[i]) begin
                slot_pos[i] = '0;
                slot_len[i] = '0;
            end
            end_ptr   = 32'((2 * SLOTS + 2) * 4);
            garbage   = '0;
            threshold = GARBAGE_THRESHOLD_RESET;
        endfunction

        function void set_threshold(bit [31:0] value);
            threshold = value;
            n_thresholds++;
        endfunction

        // place (save) or look up (load) one record, queue the result
        function void note_request(t_op op, bit [IDX_W-1:0] idx, bit [REQ_W-1:0] req);
            t_slot_result r;
            bit [31:0]    want;
            bit [31:0]    old_len;
            want = (req > MAX_RECORD_BYTES) ? 32'(MAX_RECORD_BYTES) : 32'(req);
            r = '0;
            if (int'(idx) < SLOTS) begin
                if (op == OP_SAVE) begin
                    n_saves++;
                    old_len = slot_len[idx];
                    if (old_len < want) begin
                        // grows: goes to the end, old bytes become garbage
                        r.position    = end_ptr;
                        end_ptr       = end_ptr + want;
                        garbage       = garbage + old_len;
                        slot_pos[idx] = r.position;
                        r.appended    = 1'b1;
                        n_appends++;
                    end else begin
                        // fits: rewritten in place, the slack is garbage
                        r.position = slot_pos[idx];
                        garbage    = garbage + (old_len - want);
                    end
                    slot_len[idx] = want;
                    r.size        = want;
                    r.exists      = (slot_pos[idx] != 0);
                end else begin
                    n_loads++;
                    r.position = slot_pos[idx];
                    r.size     = slot_len[idx];
                    r.exists   = (r.position != 0);
                end
            end
            r.header  = (32'(idx) * 32'd2 + 32'd2) * 32'd4;
            r.compact = (garbage >= threshold);
            if (r.compact)
                n_compact++;
            placements_due.push_back(r);
        endfunction

        function void check_result(t_slot_result got);
            t_slot_result exp;
            if (placements_due.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            exp = placements_due.pop_front();
            if (got.exists !== exp.exists) begin
                $error("exists: expected %0d, got %0d", exp.exists, got.exists);
                errors++;
            end
            if (got.position !== exp.position) begin
                $error("record_position: expected 0x%08h, got 0x%08h",
                       exp.position, got.position);
                errors++;
            end
            if (got.size !== exp.size) begin
                $error("stored_size: expected %0d, got %0d", exp.size, got.size);
                errors++;
            end
            if (got.appended !== exp.appended) begin
                $error("appended: expected %0d, got %0d", exp.appended, got.appended);
                errors++;
            end
            if (got.header !== exp.header) begin
                $error("header_address: expected 0x%08h, got 0x%08h",
                       exp.header, got.header);
                errors++;
            end
            if (got.compact !== exp.compact) begin
                $error("compact_needed: expected %0d, got %0d", exp.compact, got.compact);
                errors++;
            end
        endfunction

        function int outstanding();
            return placements_due.size();
        endfunction
    endclass

    slot_space_scoreboard sb = new();

    // idling controls, changed between phases
    bit quiet     = 1'b0;  // final stretch: no gaps, no stalls
    int gap_pct   = 20;    // chance of an input gap before a beat
    int stall_pct = 10;    // chance of a stall burst on the result side

    chunk_slot_space_allocator #(
        .SLOTS            (SLOTS),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_slot_index      (i_slot_index),
        .i_record_size     (i_record_size),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_exists          (o_exists),
        .o_record_position (o_record_position),
        .o_stored_size     (o_stored_size),
        .o_appended        (o_appended),
        .o_header_address  (o_header_address),
        .o_compact_needed  (o_compact_needed),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop at 2 ms. Slow case: the clearing pass plus ~1750 beats,
    // each with the longest input gap and the longest result stall, still
    // ends well before it.
    initial begin
        #2_000_000;
        $display("[chunk_slot_space_allocator] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, none when quiet.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0 && !quiet) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = 0;
                if (!quiet && $urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    // Outputs sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_exists, o_record_position, o_stored_size,
                              o_appended, o_header_address, o_compact_needed});
    end

    // ------------------------------------------------------------------
    // Drivers. All inputs change on the falling edge.
    // ------------------------------------------------------------------
    // APB write: setup, then access; pready is tied high so the register
    // takes the value at the edge that closes the access cycle.
    task automatic write_threshold(bit [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_GARBAGE_THRESHOLD;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_threshold(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid for a burst of idle cycles
    task automatic idle_input(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // present one request beat and hold it until it is taken
    task automatic send_request(t_op op, bit [IDX_W-1:0] idx, bit [REQ_W-1:0] req);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
            idle_input($urandom_range(1, 19));
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_slot_index  <= idx;
        i_record_size <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, idx, req);
    endtask

    // Let every outstanding result drain, then a few spare cycles, so the
    // block is idle before the threshold moves.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Random traffic. Most indexes land on a few hot slots so saves keep
    // growing and shrinking the same records; the rest spread over all
    // indexes. Sizes lean small, with zeros, near-max and oversized values.
    task automatic random_traffic(int beats);
        t_op             op;
        bit [IDX_W-1:0]  idx;
        bit [REQ_W-1:0]  req;
        int              pick;
        repeat (beats) begin
            op  = ($urandom_range(0, 9) < 7) ? OP_SAVE : OP_LOAD;
            idx = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, HOT_SLOTS - 1))
                                              : IDX_W'($urandom_range(0, SLOTS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 12)
                req = '0;
            else if (pick < 55)
                req = REQ_W'($urandom_range(1, 4096));
            else if (pick < 85)
                req = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
            else
                req = REQ_W'($urandom_range(MAX_RECORD_BYTES - 600, MAX_RECORD_BYTES + 4));
            send_request(op, idx, req);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats, reset threshold. The table clear after reset
        // simply holds off the first beat.
        send_request(OP_LOAD, 12'd0,    17'd0);       // never written
        send_request(OP_SAVE, 12'd5,    17'd0);       // empty slot, size 0: in place at 0
        send_request(OP_LOAD, 12'd5,    17'd0);
        send_request(OP_SAVE, 12'd0,    17'd100);     // first record: to the end
        send_request(OP_SAVE, 12'd0,    17'd100);     // same size: in place
        send_request(OP_SAVE, 12'd0,    17'd40);      // shrink: 60 bytes garbage
        send_request(OP_SAVE, 12'd0,    17'd0);       // zero size, slot still placed
        send_request(OP_LOAD, 12'd0,    17'h1FFFF);   // size ignored on load
        send_request(OP_SAVE, 12'd0,    17'd65536);   // largest record
        send_request(OP_SAVE, 12'd4095, 17'h1FFFF);   // oversized, clamps
        send_request(OP_SAVE, 12'd4095, 17'd65537);   // clamps to equal: in place
        send_request(OP_LOAD, 12'd4095, 17'd0);
        send_request(OP_SAVE, 12'hAAA,  17'h15555);
        send_request(OP_SAVE, 12'h555,  17'h0AAAA);
        send_request(OP_LOAD, 12'hAAA,  17'd0);
        send_request(OP_LOAD, 12'h555,  17'd0);
        send_request(OP_SAVE, 12'd1,    17'd1);
        send_request(OP_SAVE, 12'd1,    17'd2);       // grows by one
        send_request(OP_LOAD, 12'd1,    17'd0);
        drain();

        // threshold zero: compaction always requested
        write_threshold(32'd0);
        gap_pct   = 30;
        stall_pct = 15;
        random_traffic(340);
        drain();

        // largest threshold: practically never reached
        write_threshold(32'hFFFF_FFFF);
        gap_pct   = 8;
        stall_pct = 40;
        random_traffic(340);
        drain();

        // just above the current garbage, so the flag rises mid-phase
        write_threshold(sb.garbage + 32'd300_000);
        gap_pct   = 50;
        stall_pct = 5;
        random_traffic(340);
        drain();

        // equal to the current garbage: an equal-size save hits the boundary
        write_threshold(sb.garbage);
        send_request(OP_SAVE, 12'd0, 17'(sb.slot_len[0]));
        gap_pct   = 20;
        stall_pct = 20;
        random_traffic(340);
        drain();

        // back to the reset value, full rate on both sides
        write_threshold(GARBAGE_THRESHOLD_RESET);
        quiet = 1'b1;
        random_traffic(370);
        drain();

        $display("covered %0d saves (%0d grown to the end), %0d loads, %0d compaction flags",
                 sb.n_saves, sb.n_appends, sb.n_loads, sb.n_compact);
        $display("under %0d threshold settings, final garbage %0d bytes",
                 sb.n_thresholds + 1, sb.garbage);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[chunk_slot_space_allocator] OK");
        else
            $display("[chunk_slot_space_allocator] ERROR");
        $finish;
    end

endmodule
